/* src/irpb_pkg.sv */
// Shared constants and types for the integer range partition bounds block.
`timescale 1ns / 1ps
package irpb_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int SPAN_WIDTH_DEF   = 32;
  localparam int COUNT_W          = 7;
  localparam int OUT_W            = 32;
  localparam int WIDE_W           = 64;

  typedef struct packed {
    logic               load;
    logic [COUNT_W-1:0] count;
  } emit_ctrl_t;

endpackage

/* src/integer_range_partition_bounds.sv */
// Top level: request sequencer around the divider and the bound stepper.
//
// Usage: drive segment_count and total_span and raise start while busy is
// low; that edge transfers the request. The block then divides the span by
// the clamped segment count (a count of zero acts as one) with a restoring
// divider that yields one quotient bit per cycle.
// It then emits one segment bound per cycle, marked by strobe, with is_last
// high on the final bound, which equals the span.
// Requests do not overlap: a new request is taken only once the divider and
// the one-bound-per-cycle stepper are through with the last one. busy falls
// while the last bound is on the ports, so a new start may be given in that
// cycle.
// Each result stays on the ports for one cycle only; the receiver cannot
// stall the block and must take every transfer.
// Synchronous reset drops any request in flight and clears busy and strobe.
`timescale 1ns / 1ps
module integer_range_partition_bounds #(
  parameter int MAX_SEGMENTS = irpb_pkg::MAX_SEGMENTS_DEF,
  parameter int SPAN_WIDTH   = irpb_pkg::SPAN_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [irpb_pkg::COUNT_W-1:0] segment_count,
  input  logic [irpb_pkg::OUT_W-1:0]   total_span,
  output logic                         strobe,
  output logic [irpb_pkg::OUT_W-1:0]   upper_bound,
  output logic                         is_last
);

  localparam int CW = irpb_pkg::COUNT_W;
  localparam int WW = irpb_pkg::WIDE_W;
  localparam logic [CW-1:0] MAX_CLAMP =
    (MAX_SEGMENTS > (2 ** CW) - 1) ? {CW{1'b1}} : CW'(MAX_SEGMENTS);

  typedef enum logic [1:0] {IDLE, DIVIDE, EMIT} state_t;

  state_t                state;
  logic [CW-1:0]         n_reg;
  logic                  accept;
  logic [CW-1:0]         n_clamp;
  logic [WW-1:0]         span_wide;
  logic [SPAN_WIDTH-1:0] span_in;
  logic                  div_done;
  logic [SPAN_WIDTH-1:0] quotient;
  logic [CW-1:0]         remainder;
  irpb_pkg::emit_ctrl_t  ectrl;
  logic                  emit_done;
  logic [SPAN_WIDTH-1:0] bound_out;
  logic [WW-1:0]         bound_wide;

  assign accept = start && !busy;
  assign busy   = state != IDLE;

  always_comb begin
    n_clamp = segment_count;
    if (n_clamp == '0) n_clamp = CW'(1);
    if (n_clamp > MAX_CLAMP) n_clamp = MAX_CLAMP;
    span_wide = {{(WW - irpb_pkg::OUT_W){1'b0}}, total_span};
    span_in   = span_wide[SPAN_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (accept) begin
            state <= DIVIDE;
            n_reg <= n_clamp;
          end
        end
        DIVIDE: begin
          if (div_done) state <= EMIT;
        end
        EMIT: begin
          if (emit_done) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign ectrl.load  = div_done && (state == DIVIDE);
  assign ectrl.count = n_reg;

  irpb_divider #(.SPAN_WIDTH(SPAN_WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .dividend  (span_in),
    .divisor   (n_clamp),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  irpb_emitter #(.SPAN_WIDTH(SPAN_WIDTH)) u_emit (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ectrl),
    .base      (quotient),
    .spare     (remainder),
    .done      (emit_done),
    .strobe    (strobe),
    .bound_out (bound_out),
    .last_out  (is_last)
  );

  assign bound_wide  = {{(WW - SPAN_WIDTH){1'b0}}, bound_out};
  assign upper_bound = bound_wide[irpb_pkg::OUT_W-1:0];

endmodule

/* src/irpb_divider.sv */
// Restoring divider: one quotient bit per cycle, span by segment count.
`timescale 1ns / 1ps
module irpb_divider #(
  parameter int SPAN_WIDTH = irpb_pkg::SPAN_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [SPAN_WIDTH-1:0]        dividend,
  input  logic [irpb_pkg::COUNT_W-1:0] divisor,
  output logic                         done,
  output logic [SPAN_WIDTH-1:0]        quotient,
  output logic [irpb_pkg::COUNT_W-1:0] remainder
);

  localparam int CW    = irpb_pkg::COUNT_W;
  localparam int CNT_W = $clog2(SPAN_WIDTH + 1);

  logic [SPAN_WIDTH-1:0] quo;
  logic [CW-1:0]         rem;
  logic [CW-1:0]         dvs;
  logic [CNT_W-1:0]      cnt;
  logic                  run;
  logic [CW:0]           rem_sh;
  logic [CW:0]           diff;
  logic                  ge;

  // Shift in the next dividend bit, subtract when the divisor fits.
  always_comb begin
    rem_sh = {rem, quo[SPAN_WIDTH-1]};
    ge     = rem_sh >= {1'b0, dvs};
    diff   = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(SPAN_WIDTH);
        quo <= dividend;
        rem <= '0;
        dvs <= divisor;
      end else if (run) begin
        rem <= ge ? diff[CW-1:0] : rem_sh[CW-1:0];
        quo <= {quo[SPAN_WIDTH-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

/* src/irpb_emitter.sv */
// Error-diffusion stepper: one segment bound per cycle from quotient and remainder.
`timescale 1ns / 1ps
module irpb_emitter #(
  parameter int SPAN_WIDTH = irpb_pkg::SPAN_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  irpb_pkg::emit_ctrl_t         ctrl,
  input  logic [SPAN_WIDTH-1:0]        base,
  input  logic [irpb_pkg::COUNT_W-1:0] spare,
  output logic                         done,
  output logic                         strobe,
  output logic [SPAN_WIDTH-1:0]        bound_out,
  output logic                         last_out
);

  localparam int CW = irpb_pkg::COUNT_W;

  logic                  active;
  logic [CW-1:0]         n;
  logic [CW-1:0]         r;
  logic [SPAN_WIDTH-1:0] q;
  logic [CW-1:0]         idx;
  logic signed [7:0]     err;
  logic [SPAN_WIDTH-1:0] bound;

  logic signed [9:0]     e_plus_r;
  logic                  wide;
  logic signed [9:0]     err_next;
  logic [SPAN_WIDTH-1:0] bound_next;
  logic                  last_now;

  always_comb begin
    e_plus_r   = 10'(err) + $signed({3'b000, r});
    // Stay narrow on a tie.
    wide       = (e_plus_r <<< 1) > $signed({3'b000, n});
    err_next   = wide ? e_plus_r - $signed({3'b000, n}) : e_plus_r;
    bound_next = bound + q + SPAN_WIDTH'(wide);
    last_now   = (idx + 1'b1) == n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (ctrl.load) begin
        active <= 1'b1;
        n      <= ctrl.count;
        r      <= spare;
        q      <= base;
        idx    <= '0;
        err    <= '0;
        bound  <= '0;
      end else if (active) begin
        strobe    <= 1'b1;
        bound_out <= bound_next;
        last_out  <= last_now;
        bound     <= bound_next;
        err       <= err_next[7:0];
        idx       <= idx + 1'b1;
        if (last_now) active <= 1'b0;
      end
    end
  end

  assign done = active && last_now && !ctrl.load;

endmodule

/* src/irpb_checker.sv */
// Port-level checks for the partition bounds block, bound to the top level.
`timescale 1ns / 1ps
module irpb_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic strobe,
  input logic is_last
);

  // An accepted request holds the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after a start transfer");

  // Bounds of one request come back to back.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && !is_last |=> strobe)
    else $error("gap between bounds of one request");

  // Nothing follows the last bound directly.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && is_last |=> !strobe)
    else $error("strobe after the last bound");

  // A bound that is not the last is shown while the block is busy.
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !is_last |-> busy)
    else $error("intermediate bound while not busy");

endmodule

bind integer_range_partition_bounds irpb_checker u_irpb_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .strobe  (strobe),
  .is_last (is_last)
);

/* verif/integer_range_partition_bounds_tb.sv */
// Testbench for the integer range partition bounds block: queued requests, predicted bounds.
`timescale 1ns / 1ps
module integer_range_partition_bounds_tb;

  localparam int  COUNT_W          = irpb_pkg::COUNT_W;
  localparam int  OUT_W            = irpb_pkg::OUT_W;
  localparam int  MAX_SEGMENTS_DEF = irpb_pkg::MAX_SEGMENTS_DEF;
  localparam int  SPAN_WIDTH_DEF   = irpb_pkg::SPAN_WIDTH_DEF;
  localparam int  CYCLE_LIMIT = 200000;
  localparam int  TAIL_CYCLES = 2 * SPAN_WIDTH_DEF + 16;
  localparam int  RANDOM_REQS = 189;

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic [OUT_W-1:0]   span;
  } request_t;

  typedef struct {
    logic [OUT_W-1:0] bound;
    logic             last;
  } bound_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [COUNT_W-1:0] segment_count = '0;
  logic [OUT_W-1:0]   total_span = '0;
  logic               busy;
  logic               strobe;
  logic [OUT_W-1:0]   upper_bound;
  logic               is_last;

  request_t requests[$];
  bound_t   expected_bounds[$];
  int       issued = 0;
  int       accepted = 0;
  int       failures = 0;
  int       cycles = 0;

  integer_range_partition_bounds dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .segment_count(segment_count),
    .total_span(total_span),
    .strobe(strobe),
    .upper_bound(upper_bound),
    .is_last(is_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Split [0, span) into count segments by scaled error diffusion; tie stays narrow.
  function automatic void partition_bounds(input logic [COUNT_W-1:0] count,
                                           input logic [OUT_W-1:0] span);
    int unsigned      n;
    logic [OUT_W-1:0] base;
    int               spare;
    int               err;
    logic [OUT_W-1:0] edge_pos;
    bound_t           b;
    n = 32'(count);
    if (n == 0) n = 1;
    if (n > MAX_SEGMENTS_DEF) n = MAX_SEGMENTS_DEF;
    base = span / n;
    spare = int'(span % n);
    err = 0;
    edge_pos = '0;
    for (int i = 0; i < int'(n); i++) begin
      edge_pos = edge_pos + base;
      if (2 * (err + spare) <= int'(n)) begin
        err = err + spare;
      end else begin
        edge_pos = edge_pos + 1;
        err = err - (int'(n) - spare);
      end
      b.bound = edge_pos;
      b.last = (i == int'(n) - 1);
      expected_bounds.push_back(b);
    end
  endfunction

  function automatic void add_request(input logic [COUNT_W-1:0] count,
                                      input logic [OUT_W-1:0] span);
    request_t rq;
    rq.count = count;
    rq.span = span;
    requests.push_back(rq);
  endfunction

  // Driver: hold start until the transfer, then present the next request or idle.
  always @(negedge clk) begin
    request_t rq;
    logic     idle;
    if (rst) begin
      start <= 1'b0;
    end else if (start && accepted < issued) begin
      start <= 1'b1;
    end else begin
      idle = !(issued >= 100 && issued < 160) && ($urandom_range(0, 99) < 15);
      if (requests.size() != 0 && !idle) begin
        rq = requests.pop_front();
        segment_count <= rq.count;
        total_span <= rq.span;
        start <= 1'b1;
        issued = issued + 1;
      end else begin
        segment_count <= COUNT_W'($urandom);
        total_span <= $urandom;
        start <= 1'b0;
      end
    end
  end

  // Monitor: record transfers into the predictor and check every strobed bound.
  always @(posedge clk) begin
    bound_t b;
    if (!rst) begin
      if (start && !busy) begin
        partition_bounds(segment_count, total_span);
        accepted = accepted + 1;
      end
      if (strobe) begin
        if (expected_bounds.size() == 0) begin
          $error("unexpected bound: upper_bound=%0d is_last=%0b", upper_bound, is_last);
          failures = failures + 1;
        end else begin
          b = expected_bounds.pop_front();
          if (upper_bound !== b.bound) begin
            $error("upper_bound: expected %0d, actual %0d", b.bound, upper_bound);
            failures = failures + 1;
          end
          if (is_last !== b.last) begin
            $error("is_last: expected %0b, actual %0b", b.last, is_last);
            failures = failures + 1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [COUNT_W-1:0] count;
    logic [OUT_W-1:0]   span;

    // Directed: field extremes, zero and oversized counts, zero span, ties.
    add_request(7'd1, 32'hFFFF_FFFF);
    add_request(7'd0, 32'd12345);
    add_request(7'd0, 32'd0);
    add_request(7'd64, 32'hFFFF_FFFF);
    add_request(7'd65, 32'd1000);
    add_request(7'd127, 32'h8000_0000);
    add_request(7'd64, 32'd0);
    add_request(7'd5, 32'd0);
    add_request(7'd2, 32'd1);
    add_request(7'd4, 32'd2);
    add_request(7'd64, 32'd32);
    add_request(7'd7, 32'd3);
    add_request(7'd3, 32'hFFFF_FFFF);
    add_request(7'd64, 32'd63);
    add_request(7'd10, 32'd5);
    add_request(7'd5, 32'd12);
    add_request(7'd63, 32'd62);
    add_request(7'd64, 32'd65);
    add_request(7'd1, 32'd0);
    add_request(7'd33, 32'h5555_5555);
    add_request(7'd42, 32'hAAAA_AAAA);

    for (int k = 0; k < RANDOM_REQS; k++) begin
      case ($urandom_range(0, 9))
        0:       count = $urandom_range(0, 1) ? 7'd0 : COUNT_W'($urandom_range(65, 127));
        1:       count = 7'd64;
        2:       count = COUNT_W'($urandom_range(1, 4));
        default: count = COUNT_W'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 6))
        0:       span = $urandom_range(0, 200);
        1:       span = 32'hFFFF_FFFF - $urandom_range(0, 100);
        2:       span = count * $urandom_range(0, 1000) + $urandom_range(0, 3);
        3:       span = 32'd1 << $urandom_range(0, 31);
        default: span = $urandom;
      endcase
      add_request(count, span);
    end

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    while (requests.size() != 0 || accepted < issued) @(posedge clk);
    while (expected_bounds.size() != 0 || busy) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && expected_bounds.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
src/irpb_pkg.sv
src/irpb_divider.sv
src/irpb_emitter.sv
src/integer_range_partition_bounds.sv
src/irpb_checker.sv
verif/integer_range_partition_bounds_tb.sv
